@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is held.
`define SVM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be true while out of reset.
`define SVM_NEVER(lbl, cond, msg) \
    `SVM_ASSERT(lbl, !(cond), msg)

`endif

@@ rtl/core/svm_pkg.sv @@
`default_nettype none
package svm_pkg;

    // Default sizing
    localparam int VOICES_DEF     = 16;
    localparam int SLOTS_DEF      = 8;
    localparam int SLOT_BYTES_DEF = 4096;
    localparam int MAX_BUFFER_DEF = 64;

    // Command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_PLAY   = 2'd2;
    localparam logic [1:0] CMD_RENDER = 2'd3;

    // Result code for no voice claimed
    localparam logic [4:0] NO_VOICE = 5'd16;

    // Load bias: byte - 127 wraps to byte + 129
    localparam logic [7:0] LOAD_BIAS = 8'd129;

    localparam logic [6:0] BLEN_RESET = 7'd64;

    typedef logic signed [7:0] t_sample;

endpackage
`default_nettype wire

@@ rtl/core/svm_ram.sv @@
`default_nettype none
module svm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic                                 i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/svm_mix.sv @@
`default_nettype none
module svm_mix (
    input  wire svm_pkg::t_sample i_acc,
    input  wire svm_pkg::t_sample i_smp,
    output svm_pkg::t_sample      o_res
);
    import svm_pkg::*;

    logic signed [15:0] prod;
    logic        [14:0] mag;
    logic        [14:0] quo;
    logic signed [16:0] sum;

    // acc + s - acc*s/255, quotient truncated toward zero
    always_comb begin
        prod = i_acc * i_smp;
        mag  = prod[15] ? 15'(-prod) : prod[14:0];
        // exact x/255 for any 15-bit x
        quo  = 15'((16'(mag) + 16'd1 + 16'(mag[14:8])) >> 8);
        sum  = 17'(i_acc) + 17'(i_smp) - (prod[15] ? -17'(quo) : 17'(quo));
        o_res = sum[7:0];
    end
endmodule
`default_nettype wire

@@ rtl/core/sample_voice_mixer_unit.sv @@
// Sample-playback mixer. Load requests append bytes (less 127) to sample slots,
// play requests claim the lowest idle voice, clear empties all voices and slots
// and render requests return buffer_len (clamped to 1..MAX_BUFFER) mixed bytes
// (last flags the final one); every other request returns one result. Play scans
// the voices in order. Render clears the mix buffer, scans each voice and mixes
// each active voice through the single shared mix unit and mix buffer port, then
// reads out the output bytes. Input stall is high while a request is in work.
// Sample memory needs no clearing pass.
`default_nettype none
module sample_voice_mixer_unit #(
    parameter int VOICES     = svm_pkg::VOICES_DEF,
    parameter int SLOTS      = svm_pkg::SLOTS_DEF,
    parameter int SLOT_BYTES = svm_pkg::SLOT_BYTES_DEF,
    parameter int MAX_BUFFER = svm_pkg::MAX_BUFFER_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_sample_byte,
    input  wire logic        i_new_slot,
    input  wire logic [2:0]  i_sample_slot,
    input  wire logic        i_loop_flag,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output svm_pkg::t_sample o_mixed_byte,
    output logic             o_last,
    output logic [4:0]       o_voice_granted,
    output logic             o_accepted,
    // configuration
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [6:0]  i_cfg_data
);
    import svm_pkg::*;

    localparam int VW  = VOICES > 1 ? $clog2(VOICES) : 1;
    localparam int SW  = SLOTS > 1 ? $clog2(SLOTS) : 1;
    localparam int NSW = $clog2(SLOTS + 1);
    localparam int LW  = $clog2(SLOT_BYTES + 1);
    localparam int AW  = $clog2(SLOTS * SLOT_BYTES);
    localparam int KW  = MAX_BUFFER > 1 ? $clog2(MAX_BUFFER) : 1;
    localparam int CW  = $clog2(MAX_BUFFER + 1);
    localparam int MW  = (LW > CW ? LW : CW) + 1;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_PLAY  = 4'd2;
    localparam logic [3:0] S_RCLR  = 4'd3;
    localparam logic [3:0] S_VSEL  = 4'd4;
    localparam logic [3:0] S_VMIX  = 4'd5;
    localparam logic [3:0] S_ORD   = 4'd6;
    localparam logic [3:0] S_OWAIT = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    logic [3:0]    r_state;
    logic [6:0]    r_blen;

    // captured request
    logic [1:0]    r_cmd;
    logic [7:0]    r_sample_byte;
    logic          r_new_slot;
    logic [2:0]    r_sample_slot;
    logic          r_loop_flag;

    // voice and slot state
    logic [LW-1:0] r_vpos  [VOICES];
    logic [SW-1:0] r_vslot [VOICES];
    logic          r_vloop [VOICES];
    logic [LW-1:0] r_slen  [SLOTS];
    logic [NSW-1:0] r_nslots;

    // sequencer working registers
    logic [VW-1:0] r_vidx;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_base;
    logic          r_pend;
    logic [KW-1:0] r_wk;
    logic [4:0]    r_res_granted;
    logic          r_res_acc;

    // output register
    logic          r_ovalid;
    t_sample       r_o_mixed;
    logic          r_o_last;
    logic [4:0]    r_o_granted;
    logic          r_o_acc;

    // memory ports
    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic [7:0]    st_wdata;
    logic          st_re;
    logic [AW-1:0] st_raddr;
    logic [7:0]    st_rdata;
    logic          mx_we;
    logic [KW-1:0] mx_waddr;
    t_sample       mx_wdata;
    logic          mx_re;
    logic [KW-1:0] mx_raddr;
    logic [7:0]    mx_rdata;
    t_sample       mix_res;

    // load decode
    logic          ld_ok;
    logic [SW-1:0] ld_slot;
    logic [LW-1:0] ld_len;
    logic [CW-1:0] rn_val;
    logic          play_bad;

    // voice setup decode
    logic [LW-1:0] vs_pos;
    logic [SW-1:0] vs_slot;
    logic [LW-1:0] vs_len;
    logic          vs_end;
    logic          vs_stop;
    logic [LW-1:0] vs_pe;
    logic [CW-1:0] vs_cnt;
    logic [VW+4:0] gext;
    logic          issue;

    svm_ram #(.WIDTH(8), .DEPTH(SLOTS * SLOT_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    svm_ram #(.WIDTH(8), .DEPTH(MAX_BUFFER)) u_mixbuf (
        .i_clk   (i_clk),
        .i_we    (mx_we),
        .i_waddr (mx_waddr),
        .i_wdata (mx_wdata),
        .i_re    (mx_re),
        .i_raddr (mx_raddr),
        .o_rdata (mx_rdata)
    );

    svm_mix u_mix (
        .i_acc (t_sample'(mx_rdata)),
        .i_smp (t_sample'(st_rdata)),
        .o_res (mix_res)
    );

    // load target slot and admission, render length clamp and play slot check
    always_comb begin
        if (r_new_slot) begin
            ld_slot = SW'(r_nslots);
            ld_len  = '0;
            ld_ok   = r_nslots < NSW'(SLOTS);
        end else begin
            ld_slot = SW'(r_nslots - NSW'(1));
            ld_len  = r_slen[ld_slot];
            ld_ok   = (r_nslots != '0) && (ld_len < LW'(SLOT_BYTES));
        end
        if (r_blen == 7'd0) begin
            rn_val = CW'(1);
        end else if (r_blen > 7'(MAX_BUFFER)) begin
            rn_val = CW'(MAX_BUFFER);
        end else begin
            rn_val = CW'(r_blen);
        end
        play_bad = (NSW + 3)'(r_sample_slot) >= (NSW + 3)'(r_nslots);
        gext     = (VW + 5)'(r_vidx);
    end

    // per-voice end rule and mix count
    always_comb begin
        vs_pos  = r_vpos[r_vidx];
        vs_slot = r_vslot[r_vidx];
        vs_len  = r_slen[vs_slot];
        vs_end  = vs_pos == vs_len;
        vs_stop = vs_end && !r_vloop[r_vidx];
        vs_pe   = vs_end ? LW'(1) : vs_pos;
        if (MW'(vs_pe) + MW'(r_n) <= MW'(vs_len)) begin
            vs_cnt = r_n;
        end else if (vs_pe < vs_len) begin
            vs_cnt = CW'(vs_len - vs_pe);
        end else begin
            vs_cnt = '0;
        end
    end

    // memory port control
    always_comb begin
        issue    = (r_state == S_VMIX) && (r_k < r_cnt);
        st_we    = (r_state == S_EXEC) && (r_cmd == CMD_LOAD) && ld_ok;
        st_waddr = AW'(ld_slot) * AW'(SLOT_BYTES) + AW'(ld_len);
        st_wdata = r_sample_byte + LOAD_BIAS;
        st_re    = issue;
        st_raddr = r_base + AW'(r_k);
        mx_we    = (r_state == S_RCLR) || r_pend;
        mx_waddr = (r_state == S_RCLR) ? r_k[KW-1:0] : r_wk;
        mx_wdata = (r_state == S_RCLR) ? t_sample'(0) : mix_res;
        mx_re    = issue || (r_state == S_ORD);
        mx_raddr = r_k[KW-1:0];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_blen   <= BLEN_RESET;
            r_nslots <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
            for (int v = 0; v < VOICES; v++) begin
                r_vpos[v]  <= '0;
                r_vslot[v] <= '0;
                r_vloop[v] <= 1'b0;
            end
            for (int s = 0; s < SLOTS; s++) begin
                r_slen[s] <= '0;
            end
        end else begin
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_blen <= i_cfg_data;
            end
            r_pend <= issue;
            r_wk   <= r_k[KW-1:0];
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd         <= i_cmd;
                        r_sample_byte <= i_sample_byte;
                        r_new_slot    <= i_new_slot;
                        r_sample_slot <= i_sample_slot;
                        r_loop_flag   <= i_loop_flag;
                        r_state       <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res_granted <= NO_VOICE;
                    r_res_acc     <= 1'b0;
                    r_vidx        <= '0;
                    r_k           <= '0;
                    r_n           <= rn_val;
                    case (r_cmd)
                        CMD_CLEAR: begin
                            for (int v = 0; v < VOICES; v++) begin
                                r_vpos[v]  <= '0;
                                r_vslot[v] <= '0;
                                r_vloop[v] <= 1'b0;
                            end
                            for (int s = 0; s < SLOTS; s++) begin
                                r_slen[s] <= '0;
                            end
                            r_nslots <= '0;
                            r_state  <= S_EMIT;
                        end
                        CMD_LOAD: begin
                            if (ld_ok) begin
                                r_slen[ld_slot] <= ld_len + LW'(1);
                                if (r_new_slot) begin
                                    r_nslots <= r_nslots + NSW'(1);
                                end
                            end
                            r_res_acc <= ld_ok;
                            r_state   <= S_EMIT;
                        end
                        CMD_PLAY: begin
                            r_state <= play_bad ? S_EMIT : S_PLAY;
                        end
                        default: begin
                            r_state <= S_RCLR;
                        end
                    endcase
                end
                S_PLAY: begin
                    if (r_vpos[r_vidx] == '0 && !r_vloop[r_vidx]) begin
                        r_vpos[r_vidx]  <= LW'(1);
                        r_vslot[r_vidx] <= SW'(r_sample_slot);
                        r_vloop[r_vidx] <= r_loop_flag;
                        r_res_granted   <= gext[4:0];
                        r_res_acc       <= 1'b1;
                        r_state         <= S_EMIT;
                    end else if (r_vidx == VW'(VOICES - 1)) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_vidx <= r_vidx + VW'(1);
                    end
                end
                S_RCLR: begin
                    if (r_k == r_n - CW'(1)) begin
                        r_state <= S_VSEL;
                    end else begin
                        r_k <= r_k + CW'(1);
                    end
                end
                S_VSEL: begin
                    r_k    <= '0;
                    r_cnt  <= vs_cnt;
                    r_base <= AW'(vs_slot) * AW'(SLOT_BYTES) + AW'(vs_pe - LW'(1));
                    if (vs_pos == '0 || vs_stop || vs_cnt == '0) begin
                        if (vs_stop) begin
                            r_vpos[r_vidx] <= '0;
                        end else if (vs_pos != '0) begin
                            r_vpos[r_vidx] <= vs_pe;
                        end
                        if (r_vidx == VW'(VOICES - 1)) begin
                            r_state <= S_ORD;
                        end else begin
                            r_vidx <= r_vidx + VW'(1);
                        end
                    end else begin
                        r_vpos[r_vidx] <= LW'(MW'(vs_pe) + MW'(vs_cnt));
                        r_state        <= S_VMIX;
                    end
                end
                S_VMIX: begin
                    if (issue) begin
                        r_k <= r_k + CW'(1);
                    end else if (!r_pend) begin
                        r_k <= '0;
                        if (r_vidx == VW'(VOICES - 1)) begin
                            r_state <= S_ORD;
                        end else begin
                            r_vidx  <= r_vidx + VW'(1);
                            r_state <= S_VSEL;
                        end
                    end
                end
                S_ORD: begin
                    r_state <= S_OWAIT;
                end
                S_OWAIT: begin
                    if (!r_ovalid) begin
                        r_ovalid    <= 1'b1;
                        r_o_mixed   <= t_sample'(mx_rdata);
                        r_o_last    <= r_k == r_n - CW'(1);
                        r_o_granted <= NO_VOICE;
                        r_o_acc     <= 1'b0;
                        if (r_k == r_n - CW'(1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + CW'(1);
                            r_state <= S_ORD;
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_ovalid) begin
                        r_ovalid    <= 1'b1;
                        r_o_mixed   <= t_sample'(0);
                        r_o_last    <= 1'b1;
                        r_o_granted <= r_res_granted;
                        r_o_acc     <= r_res_acc;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = r_state != S_IDLE;
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_ovalid;
    assign o_mixed_byte    = r_o_mixed;
    assign o_last          = r_o_last;
    assign o_voice_granted = r_o_granted;
    assign o_accepted      = r_o_acc;

`include "assert_macros.svh"

    `SVM_ASSERT(a_accept_exec, (i_in_valid && !o_in_stall) |=> (r_state == S_EXEC), "request not dispatched")
    `SVM_NEVER(a_slots_bound, r_nslots > NSW'(SLOTS), "slot count overflow")
    `SVM_ASSERT(a_pend_in_mix, r_pend |-> (r_state == S_VMIX), "mix write outside mix phase")
    `SVM_ASSERT(a_grant_acc, (r_ovalid && r_o_granted != NO_VOICE) |-> r_o_acc, "grant without accept")

endmodule
`default_nettype wire

@@ sim/tb_sample_voice_mixer_unit.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_sample_voice_mixer_unit;
    import svm_pkg::*;

    localparam int NV = 16;
    localparam int NS = 8;
    localparam int SB = 4096;
    localparam int MB = 64;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] raw;
        logic       fresh;
        logic [2:0] slot;
        logic       loop_on;
    } mix_req_t;

    typedef struct {
        logic [7:0] mixed;
        logic       last;
        logic [4:0] granted;
        logic       accepted;
    } mix_rsp_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [1:0] i_cmd = CMD_CLEAR;
    logic [7:0] i_sample_byte = '0;
    logic i_new_slot = 1'b0;
    logic [2:0] i_sample_slot = '0;
    logic i_loop_flag = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_sample o_mixed_byte;
    logic o_last;
    logic [4:0] o_voice_granted;
    logic o_accepted;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [6:0] i_cfg_data = '0;

    sample_voice_mixer_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_cmd(i_cmd), .i_sample_byte(i_sample_byte), .i_new_slot(i_new_slot),
        .i_sample_slot(i_sample_slot), .i_loop_flag(i_loop_flag),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_mixed_byte(o_mixed_byte), .o_last(o_last),
        .o_voice_granted(o_voice_granted), .o_accepted(o_accepted),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the mixer state
    logic [6:0]  blen_q;
    logic [12:0] vpos_q [NV];
    logic [2:0]  vslot_q [NV];
    logic        vloop_q [NV];
    logic [7:0]  smem_q [NS*SB];
    logic [12:0] slen_q [NS];
    logic [3:0]  nslots_q;
    logic [7:0]  mixbuf_q [MB];

    mix_req_t pending_reqs[$];
    mix_rsp_t expected_results[$];
    mix_req_t cur_req;
    int errors = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit quiet = 0;
    bit hold_req = 0;
    bit hold_done = 0;

    function automatic mix_rsp_t one_rsp(logic [7:0] m, logic l, logic [4:0] g, logic a);
        mix_rsp_t r;
        r.mixed = m; r.last = l; r.granted = g; r.accepted = a;
        return r;
    endfunction

    function automatic void clear_voices_slots();
        for (int v = 0; v < NV; v++) begin
            vpos_q[v] = '0; vslot_q[v] = '0; vloop_q[v] = 1'b0;
        end
        for (int s = 0; s < NS; s++) slen_q[s] = '0;
        nslots_q = '0;
    endfunction

    // compute expected responses for one accepted request
    function automatic void mixer_predict(mix_req_t rq);
        int sl, n, p, len, cnt, a, s, r;
        logic ok;
        logic [4:0] g;
        case (rq.cmd)
            CMD_CLEAR: begin
                clear_voices_slots();
                expected_results.push_back(one_rsp(8'd0, 1'b1, NO_VOICE, 1'b0));
            end
            CMD_LOAD: begin
                ok = 1'b1;
                if (rq.fresh) begin
                    if (nslots_q >= NS) ok = 1'b0;
                    else begin
                        sl = nslots_q; nslots_q++; slen_q[sl] = '0;
                    end
                end else if (nslots_q == 0) ok = 1'b0;
                else sl = nslots_q - 1;
                if (ok && slen_q[sl] >= SB) ok = 1'b0;
                if (ok) begin
                    smem_q[sl*SB + slen_q[sl]] = rq.raw - 8'd127;
                    slen_q[sl]++;
                end
                expected_results.push_back(one_rsp(8'd0, 1'b1, NO_VOICE, ok));
            end
            CMD_PLAY: begin
                g = NO_VOICE;
                if (rq.slot < nslots_q) begin
                    for (int v = 0; v < NV; v++) begin
                        if (g == NO_VOICE && vpos_q[v] == 0 && !vloop_q[v]) begin
                            vpos_q[v] = 13'd1; vslot_q[v] = rq.slot;
                            vloop_q[v] = rq.loop_on; g = v[4:0];
                        end
                    end
                end
                expected_results.push_back(one_rsp(8'd0, 1'b1, g, g != NO_VOICE));
            end
            default: begin
                n = (blen_q == 0) ? 1 : (blen_q > MB) ? MB : blen_q;
                for (int k = 0; k < MB; k++) mixbuf_q[k] = '0;
                for (int v = 0; v < NV; v++) begin
                    if (vpos_q[v] != 0) begin
                        sl = vslot_q[v];
                        len = slen_q[sl];
                        if (vpos_q[v] == len) begin
                            if (vloop_q[v]) vpos_q[v] = 13'd1;
                            else vpos_q[v] = '0;
                        end
                        if (vpos_q[v] != 0) begin
                            p = vpos_q[v];
                            cnt = (p + n <= len) ? n : (p < len) ? len - p : 0;
                            vpos_q[v] = 13'(p + cnt);
                            for (int k = 0; k < cnt; k++) begin
                                a = $signed(mixbuf_q[k]);
                                s = $signed(smem_q[sl*SB + p - 1 + k]);
                                r = a + s - (a * s) / 255;
                                mixbuf_q[k] = r[7:0];
                            end
                        end
                    end
                end
                for (int k = 0; k < n; k++)
                    expected_results.push_back(one_rsp(mixbuf_q[k], k + 1 == n, NO_VOICE, 1'b0));
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // request driver
    always @(posedge i_clk) begin
        logic nv;
        logic taken;
        taken = 1'b0;
        nv = i_in_valid;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                mixer_predict(cur_req);
                taken = 1'b1;
            end
            if (!i_in_valid || taken) begin
                nv = 1'b0;
                if (gap_left > 0) gap_left--;
                else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    nv = 1'b1;
                    i_cmd <= cur_req.cmd;
                    i_sample_byte <= cur_req.raw;
                    i_new_slot <= cur_req.fresh;
                    i_sample_slot <= cur_req.slot;
                    i_loop_flag <= cur_req.loop_on;
                    if (!quiet && $urandom_range(7) == 0) gap_left = $urandom_range(1, 6);
                end
            end
        end
        i_in_valid <= nv;
    end

    // response stall: random bursts, plus one long hold-off
    always @(posedge i_clk) begin
        logic st;
        st = 1'b0;
        if (hold_req && !hold_done) begin
            hold_done = 1;
            hold_left = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            st = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            st = 1'b1;
        end else if (!quiet && $urandom_range(9) == 0) begin
            stall_left = $urandom_range(0, 5);
            st = 1'b1;
        end
        i_out_stall <= st;
    end

    // response checker
    always @(posedge i_clk) begin
        mix_rsp_t w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) report_mismatch("unexpected response", 1, 0);
            else begin
                w = expected_results.pop_front();
                if (o_mixed_byte !== w.mixed)
                    report_mismatch("mixed_byte", $signed(o_mixed_byte), $signed(w.mixed));
                if (o_last !== w.last) report_mismatch("last", o_last, w.last);
                if (o_voice_granted !== w.granted)
                    report_mismatch("voice_granted", o_voice_granted, w.granted);
                if (o_accepted !== w.accepted) report_mismatch("accepted", o_accepted, w.accepted);
            end
        end
    end

    function automatic mix_req_t mk(logic [1:0] c, logic [7:0] b, logic f, logic [2:0] s,
                                    logic l);
        mix_req_t r;
        r.cmd = c; r.raw = b; r.fresh = f; r.slot = s; r.loop_on = l;
        return r;
    endfunction

    function automatic mix_req_t rand_req();
        int pick;
        pick = $urandom_range(99);
        if (pick < 4)
            return mk(CMD_CLEAR, 8'($urandom), 1'($urandom), 3'($urandom), 1'($urandom));
        if (pick < 45)
            return mk(CMD_LOAD, 8'($urandom), $urandom_range(5) == 0, 3'($urandom),
                      1'($urandom));
        if (pick < 70)
            return mk(CMD_PLAY, 8'($urandom), 1'($urandom), 3'($urandom_range(7)),
                      $urandom_range(3) == 0);
        return mk(CMD_RENDER, 8'($urandom), 1'($urandom), 3'($urandom), 1'($urandom));
    endfunction

    task automatic drain();
        while (pending_reqs.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_blen(logic [6:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        blen_q = v;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [6:0] blens [6];
        blen_q = BLEN_RESET;
        clear_voices_slots();
        for (int k = 0; k < MB; k++) mixbuf_q[k] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-state cases, byte extremes, voice exhaustion, slot limits
        pending_reqs.push_back(mk(CMD_LOAD, 8'hFF, 1'b0, 3'd0, 1'b0));
        pending_reqs.push_back(mk(CMD_PLAY, 8'h00, 1'b0, 3'd0, 1'b0));
        pending_reqs.push_back(mk(CMD_RENDER, 8'h00, 1'b0, 3'd0, 1'b0));
        pending_reqs.push_back(mk(CMD_LOAD, 8'h00, 1'b1, 3'd7, 1'b1));
        pending_reqs.push_back(mk(CMD_LOAD, 8'hFF, 1'b0, 3'd0, 1'b0));
        pending_reqs.push_back(mk(CMD_LOAD, 8'h7F, 1'b0, 3'd0, 1'b0));
        pending_reqs.push_back(mk(CMD_LOAD, 8'h80, 1'b0, 3'd0, 1'b0));
        pending_reqs.push_back(mk(CMD_LOAD, 8'h01, 1'b0, 3'd0, 1'b0));
        pending_reqs.push_back(mk(CMD_PLAY, 8'h00, 1'b0, 3'd0, 1'b0));
        pending_reqs.push_back(mk(CMD_PLAY, 8'h00, 1'b0, 3'd0, 1'b1));
        pending_reqs.push_back(mk(CMD_PLAY, 8'h00, 1'b0, 3'd1, 1'b0));
        pending_reqs.push_back(mk(CMD_RENDER, 8'h00, 1'b0, 3'd0, 1'b0));
        pending_reqs.push_back(mk(CMD_RENDER, 8'h00, 1'b0, 3'd0, 1'b0));
        for (int s = 1; s < NS + 1; s++)
            pending_reqs.push_back(mk(CMD_LOAD, 8'(s * 37), 1'b1, 3'd0, 1'b0));
        pending_reqs.push_back(mk(CMD_PLAY, 8'h00, 1'b0, 3'd7, 1'b1));
        for (int v = 0; v < NV + 1; v++)
            pending_reqs.push_back(mk(CMD_PLAY, 8'h00, 1'b0, 3'd0, 1'b1));
        pending_reqs.push_back(mk(CMD_RENDER, 8'h00, 1'b0, 3'd0, 1'b0));
        pending_reqs.push_back(mk(CMD_CLEAR, 8'hFF, 1'b1, 3'd7, 1'b1));
        drain();

        // random phases, each under its own render length
        blens[0] = 7'd1; blens[1] = 7'd0; blens[2] = 7'd17;
        blens[3] = 7'd127; blens[4] = 7'($urandom_range(2, 63)); blens[5] = 7'd64;
        for (int ph = 0; ph < 6; ph++) begin
            write_blen(blens[ph]);
            if (ph == 5) quiet = 1;
            pending_reqs.push_back(mk(CMD_CLEAR, 8'h00, 1'b0, 3'd0, 1'b0));
            for (int k = 0; k < 11; k++) pending_reqs.push_back(rand_req());
            if (ph == 2) hold_req = 1;
            drain();
        end

        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl/core
rtl/core/svm_pkg.sv
rtl/core/svm_ram.sv
rtl/core/svm_mix.sv
rtl/core/sample_voice_mixer_unit.sv
sim/tb_sample_voice_mixer_unit.sv
